FILE: rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Shared widths, constants, register indexes and the divider status type.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int TIME_BITS   = 24;
   localparam int SAMPLE_BITS = 16;

   // Level is Q1.15 and may reach full scale, which still fits in 16 bits.
   localparam int LEVEL_W = 16;
   localparam int SUS_MOD_W = 17;
   localparam int MUL_A_W = LEVEL_W;
   localparam int MUL_B_W = TIME_BITS;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int QUOT_W  = LEVEL_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = TIME_BITS;
   localparam int OFFSET_W = 15;

   localparam logic [LEVEL_W-1:0]   FULL_SCALE = LEVEL_W'(32768);
   localparam logic [TIME_BITS-1:0] TMAX       = {TIME_BITS{1'b1}};

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_TIME     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GATE_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CV_SCALE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CV_OFFSET      = 3'd6;

   // Envelope stages.
   localparam logic [1:0] STAGE_ATTACK  = 2'd0;
   localparam logic [1:0] STAGE_DECAY   = 2'd1;
   localparam logic [1:0] STAGE_SUSTAIN = 2'd2;
   localparam logic [1:0] STAGE_RELEASE = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Base time plus signed offset, clamped to the time range; zero counts as one.
   function automatic logic [TIME_BITS-1:0] eff_time(input logic [TIME_BITS-1:0] base,
                                                     input logic [TIME_BITS-1:0] offs);
      logic [TIME_BITS+1:0] sum;
      logic [TIME_BITS-1:0] res;
      sum = {2'b00, base} + {{2{offs[TIME_BITS-1]}}, offs};
      if (sum[TIME_BITS+1]) begin
         res = TIME_BITS'(1);
      end else if (sum[TIME_BITS]) begin
         res = TMAX;
      end else if (sum[TIME_BITS-1:0] == '0) begin
         res = TIME_BITS'(1);
      end else begin
         res = sum[TIME_BITS-1:0];
      end
      return res;
   endfunction

   // Base sustain plus signed offset, clamped to zero and full scale.
   function automatic logic [LEVEL_W-1:0] eff_sustain(input logic [LEVEL_W-1:0] base,
                                                      input logic [SUS_MOD_W-1:0] offs);
      logic [SUS_MOD_W+1:0] sum;
      logic [LEVEL_W-1:0]   res;
      sum = {3'b000, base} + {{2{offs[SUS_MOD_W-1]}}, offs};
      if (sum[SUS_MOD_W+1]) begin
         res = '0;
      end else if (sum[SUS_MOD_W:0] > {{(SUS_MOD_W+1-LEVEL_W){1'b0}}, FULL_SCALE}) begin
         res = FULL_SCALE;
      end else begin
         res = sum[LEVEL_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/adsr_mul.sv
// ----------------------------------------------------------------------------
// ADSR shared multiplier
// Unsigned 16 x 24 multiplier with a registered product, shared by the
// attack end test, the decay and release numerators and the CV scaling.
// ----------------------------------------------------------------------------
module adsr_mul (
   input  logic                        clock,
   input  logic [adsr_pkg::MUL_A_W-1:0] op_a,
   input  logic [adsr_pkg::MUL_B_W-1:0] op_b,
   output logic [adsr_pkg::PROD_W-1:0]  prod
);

   logic [adsr_pkg::PROD_W-1:0] prod_ff;
   logic [adsr_pkg::PROD_W-1:0] prod_in;

   assign prod_in = {{adsr_pkg::MUL_B_W{1'b0}}, op_a} * {{adsr_pkg::MUL_A_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR iterative divider
// Restoring divider producing one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUOT_W bits, so the upper numerator
// bits are loaded straight into the partial remainder.
// ----------------------------------------------------------------------------
module adsr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [adsr_pkg::PROD_W-1:0]    numer,
   input  logic [adsr_pkg::TIME_BITS-1:0] denom,
   output logic [adsr_pkg::QUOT_W-1:0]    quot,
   output adsr_pkg::div_status_type       status
);

   localparam int CNT_W = $clog2(adsr_pkg::QUOT_W);
   localparam int TW    = adsr_pkg::TIME_BITS;
   localparam int QW    = adsr_pkg::QUOT_W;

   logic [TW-1:0]    rem_ff,   rem_in;
   logic [QW-1:0]    bits_ff,  bits_in;
   logic [TW-1:0]    den_ff,   den_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   logic             busy_ff,  busy_in;
   logic             done_ff,  done_in;
   logic [TW:0]      trial;
   logic [TW:0]      diff;

   assign trial = {rem_ff, bits_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer[adsr_pkg::PROD_W-1:QW];
         bits_in = numer[QW-1:0];
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[TW]) begin
            rem_in  = diff[TW-1:0];
            bits_in = {bits_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial[TW-1:0];
            bits_in = {bits_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      den_ff  <= den_in;
   end

   assign quot        = bits_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/adsr_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Linear attack, decay, sustain and release envelope with per-sample
// modulation offsets, computed by a small sequencer around one shared
// multiplier and one iterative divider.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Content
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | gate sample and four offsets
//   rsp     | out       | rsp_valid / rsp_stall | level, CV, stage, running
//   csr     | in        | csr_wr_en             | register index and write data
//
// A transaction passes the step, attack compare, level, finish and CV states
// when the level needs no division (idle, sustain, or a finished decay or
// release); otherwise it also waits on the 16-step restoring divider.
// The block takes one request transaction at a time: req_stall stays high from
// the cycle after acceptance until the result sits in the output register,
// and also while reset is held.
// A stalled response holds the sequencer in its last state; nothing is lost.
// Reset is synchronous and restores the configuration registers to their
// defaults and the envelope to idle. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_gate_sample,
   input  logic signed [23:0]               req_attack_mod,
   input  logic signed [23:0]               req_decay_mod,
   input  logic signed [16:0]               req_sustain_mod,
   input  logic signed [23:0]               req_release_mod,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_env_level,
   output logic signed [15:0]               rsp_cv_value,
   output logic [1:0]                       rsp_stage,
   output logic                             rsp_running,

   input  logic                             csr_wr_en,
   input  logic [adsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [adsr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TW = adsr_pkg::TIME_BITS;
   localparam int LW = adsr_pkg::LEVEL_W;
   localparam int PW = adsr_pkg::PROD_W;
   localparam int QW = adsr_pkg::QUOT_W;
   localparam int SW = adsr_pkg::SAMPLE_BITS;

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STEP = 3'd1;
   localparam logic [2:0] S_ACMP = 3'd2;
   localparam logic [2:0] S_LVL  = 3'd3;
   localparam logic [2:0] S_NUM  = 3'd4;
   localparam logic [2:0] S_DIVW = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_CVO  = 3'd7;

   // Configuration registers.
   logic [TW-1:0]                   attack_time_ff;
   logic [TW-1:0]                   decay_time_ff;
   logic [LW-1:0]                   sustain_level_ff;
   logic [TW-1:0]                   release_time_ff;
   logic signed [15:0]              gate_threshold_ff;
   logic [15:0]                     cv_scale_ff;
   logic [adsr_pkg::OFFSET_W-1:0]   cv_offset_ff;

   // Per-transaction operands, captured at acceptance.
   logic [TW-1:0] a_ff, d_ff, r_ff;
   logic [LW-1:0] s_ff;
   logic          held_ff, rise_ff;

   // Envelope state.
   logic [2:0]    state_ff,         state_in;
   logic [1:0]    stage_ff,         stage_in;
   logic [TW-1:0] elapsed_ff,       elapsed_in;
   logic          active_ff,        active_in;
   logic          gate_below_ff,    gate_below_in;
   logic [LW-1:0] attack_start_ff,  attack_start_in;
   logic [LW-1:0] release_start_ff, release_start_in;
   logic [LW-1:0] last_level_ff,    last_level_in;
   logic [LW-1:0] level_ff,         level_in;
   logic          acmp_ff,          acmp_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    rsp_level_ff;
   logic signed [15:0] rsp_cv_ff;
   logic [1:0]       rsp_stage_ff;
   logic             rsp_running_ff;
   logic             rsp_load;

   // Shared units.
   logic [adsr_pkg::MUL_A_W-1:0] mul_a;
   logic [adsr_pkg::MUL_B_W-1:0] mul_b;
   logic [PW-1:0]                mul_q;
   logic                         div_start;
   logic [PW-1:0]                div_num;
   logic [TW-1:0]                div_den;
   logic [QW-1:0]                div_q;
   adsr_pkg::div_status_type     div_status;

   logic          req_accept;
   logic [TW-1:0] elapsed_inc;
   logic [LW:0]   attack_sum;
   logic [17:0]   cv_full;
   logic signed [15:0] cv_sat;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = reset || (state_ff != S_IDLE);

   // ------------------------------------------------------------------------
   // Configuration port. Writes to an index beyond the list are ignored.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_time_ff    <= TW'(480);
         decay_time_ff     <= TW'(2400);
         sustain_level_ff  <= LW'(3277);
         release_time_ff   <= TW'(14400);
         gate_threshold_ff <= 16'sd8192;
         cv_scale_ff       <= 16'hFFFF;
         cv_offset_ff      <= adsr_pkg::OFFSET_W'(32767);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            adsr_pkg::REG_ATTACK_TIME:    attack_time_ff    <= csr_wdata;
            adsr_pkg::REG_DECAY_TIME:     decay_time_ff     <= csr_wdata;
            adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_ff  <= csr_wdata[LW-1:0];
            adsr_pkg::REG_RELEASE_TIME:   release_time_ff   <= csr_wdata;
            adsr_pkg::REG_GATE_THRESHOLD: gate_threshold_ff <= $signed(csr_wdata[15:0]);
            adsr_pkg::REG_CV_SCALE:       cv_scale_ff       <= csr_wdata[15:0];
            adsr_pkg::REG_CV_OFFSET:      cv_offset_ff      <= csr_wdata[adsr_pkg::OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Operand capture. Effective times and sustain are formed from the
   // request fields at acceptance and held for the whole transaction.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_ff    <= adsr_pkg::eff_time(attack_time_ff,  req_attack_mod);
         d_ff    <= adsr_pkg::eff_time(decay_time_ff,   req_decay_mod);
         r_ff    <= adsr_pkg::eff_time(release_time_ff, req_release_mod);
         s_ff    <= adsr_pkg::eff_sustain(sustain_level_ff, req_sustain_mod);
         held_ff <= (req_gate_sample > gate_threshold_ff);
         rise_ff <= gate_below_ff && (req_gate_sample > gate_threshold_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Shared multiplier operand selection. In the step state it forms the
   // attack end bound, in the level state the decay or release numerator,
   // and at the end the CV product.
   // ------------------------------------------------------------------------
   always_comb begin
      unique case (state_ff)
         S_STEP: begin
            mul_a = LW'({1'b0, adsr_pkg::FULL_SCALE} - {1'b0, attack_start_ff});
            mul_b = a_ff;
         end
         S_LVL: begin
            if (stage_ff == adsr_pkg::STAGE_DECAY) begin
               mul_a = LW'({1'b0, adsr_pkg::FULL_SCALE} - {1'b0, s_ff});
               mul_b = elapsed_ff;
            end else begin
               mul_a = release_start_ff;
               mul_b = r_ff - elapsed_ff;
            end
         end
         default: begin
            mul_a = cv_scale_ff;
            mul_b = {{(TW-LW){1'b0}}, level_ff};
         end
      endcase
   end

   adsr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_q)
   );

   // The attack numerator is elapsed scaled by full scale, a plain shift.
   assign div_start = (state_ff == S_NUM);
   assign div_num   = (stage_ff == adsr_pkg::STAGE_ATTACK) ?
                      {1'b0, elapsed_ff, 15'b0} : mul_q;
   always_comb begin
      case (stage_ff)
         adsr_pkg::STAGE_ATTACK: div_den = a_ff;
         adsr_pkg::STAGE_DECAY:  div_den = d_ff;
         default:                div_den = r_ff;
      endcase
   end

   adsr_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (div_num),
      .denom  (div_den),
      .quot   (div_q),
      .status (div_status)
   );

   assign elapsed_inc = (elapsed_ff != adsr_pkg::TMAX) ? elapsed_ff + TW'(1) : elapsed_ff;
   assign attack_sum  = {1'b0, attack_start_ff} + {1'b0, div_q};

   // CV: scaled level minus offset, saturated to the signed sample range.
   assign cv_full = {2'b00, mul_q[30:15]} - {3'b000, cv_offset_ff};
   always_comb begin
      if ($signed(cv_full) > $signed(18'((1 << (SW - 1)) - 1))) begin
         cv_sat = 16'sh7FFF;
      end else if ($signed(cv_full) < $signed(-18'(1 << (SW - 1)))) begin
         cv_sat = 16'sh8000;
      end else begin
         cv_sat = $signed(cv_full[15:0]);
      end
   end

   assign rsp_load = (state_ff == S_CVO) && (!rsp_valid_ff || !rsp_stall);

   // ------------------------------------------------------------------------
   // Sequencer and envelope state update.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      stage_in         = stage_ff;
      elapsed_in       = elapsed_ff;
      active_in        = active_ff;
      gate_below_in    = gate_below_ff;
      attack_start_in  = attack_start_ff;
      release_start_in = release_start_ff;
      last_level_in    = last_level_ff;
      level_in         = level_ff;
      acmp_in          = acmp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               gate_below_in = (req_gate_sample < gate_threshold_ff);
               state_in      = S_STEP;
            end
         end
         S_STEP: begin
            acmp_in = 1'b0;
            if (rise_ff) begin
               // A rising gate restarts the attack from wherever the level was.
               attack_start_in  = last_level_ff;
               stage_in         = adsr_pkg::STAGE_ATTACK;
               elapsed_in       = '0;
               active_in        = 1'b1;
               release_start_in = '0;
            end else if (active_ff) begin
               elapsed_in = elapsed_inc;
               if (!held_ff && stage_ff != adsr_pkg::STAGE_RELEASE) begin
                  stage_in   = adsr_pkg::STAGE_RELEASE;
                  elapsed_in = '0;
               end else begin
                  case (stage_ff)
                     adsr_pkg::STAGE_ATTACK: acmp_in = 1'b1;
                     adsr_pkg::STAGE_DECAY: begin
                        if (elapsed_inc > d_ff) begin
                           stage_in   = adsr_pkg::STAGE_SUSTAIN;
                           elapsed_in = '0;
                        end
                     end
                     adsr_pkg::STAGE_SUSTAIN: begin
                     end
                     default: begin
                        if (elapsed_inc > r_ff) begin
                           stage_in         = adsr_pkg::STAGE_ATTACK;
                           elapsed_in       = '0;
                           active_in        = 1'b0;
                           release_start_in = '0;
                        end
                     end
                  endcase
               end
            end
            state_in = S_ACMP;
         end
         S_ACMP: begin
            // Attack ends once the exact level would pass full scale.
            if (acmp_ff && ({1'b0, elapsed_ff, 15'b0} > mul_q)) begin
               stage_in   = adsr_pkg::STAGE_DECAY;
               elapsed_in = '0;
            end
            state_in = S_LVL;
         end
         S_LVL: begin
            state_in = S_FIN;
            if (!active_ff) begin
               level_in = '0;
            end else begin
               case (stage_ff)
                  adsr_pkg::STAGE_ATTACK: state_in = S_NUM;
                  adsr_pkg::STAGE_DECAY: begin
                     if (elapsed_ff >= d_ff) begin
                        level_in = s_ff;
                     end else begin
                        state_in = S_NUM;
                     end
                  end
                  adsr_pkg::STAGE_SUSTAIN: level_in = s_ff;
                  default: begin
                     if (elapsed_ff >= r_ff) begin
                        level_in = '0;
                     end else begin
                        state_in = S_NUM;
                     end
                  end
               endcase
            end
         end
         S_NUM: begin
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_status.done) begin
               case (stage_ff)
                  adsr_pkg::STAGE_ATTACK: begin
                     if (attack_sum > {1'b0, adsr_pkg::FULL_SCALE}) begin
                        level_in = adsr_pkg::FULL_SCALE;
                     end else begin
                        level_in = attack_sum[LW-1:0];
                     end
                  end
                  adsr_pkg::STAGE_DECAY: begin
                     if (div_q > adsr_pkg::FULL_SCALE) begin
                        level_in = '0;
                     end else begin
                        level_in = adsr_pkg::FULL_SCALE - div_q;
                     end
                  end
                  default: begin
                     if (div_q > adsr_pkg::FULL_SCALE) begin
                        level_in = adsr_pkg::FULL_SCALE;
                     end else begin
                        level_in = div_q;
                     end
                  end
               endcase
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // Outside release the level reached so far is what release starts from.
            if (active_ff && stage_ff != adsr_pkg::STAGE_RELEASE) begin
               release_start_in = level_ff;
            end
            last_level_in = level_ff;
            state_in      = S_CVO;
         end
         S_CVO: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         stage_ff         <= adsr_pkg::STAGE_ATTACK;
         elapsed_ff       <= '0;
         active_ff        <= 1'b0;
         gate_below_ff    <= 1'b1;
         attack_start_ff  <= '0;
         release_start_ff <= '0;
         last_level_ff    <= '0;
         acmp_ff          <= 1'b0;
      end else begin
         state_ff         <= state_in;
         stage_ff         <= stage_in;
         elapsed_ff       <= elapsed_in;
         active_ff        <= active_in;
         gate_below_ff    <= gate_below_in;
         attack_start_ff  <= attack_start_in;
         release_start_ff <= release_start_in;
         last_level_ff    <= last_level_in;
         acmp_ff          <= acmp_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   // ------------------------------------------------------------------------
   // Output register. A waiting result is cleared when taken and replaced
   // when the sequencer finishes the next transaction.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_level_ff   <= level_ff;
         rsp_cv_ff      <= cv_sat;
         rsp_stage_ff   <= stage_ff;
         rsp_running_ff <= active_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_env_level = rsp_level_ff;
   assign rsp_cv_value  = rsp_cv_ff;
   assign rsp_stage     = rsp_stage_ff;
   assign rsp_running   = rsp_running_ff;

`ifndef ASSERT_OFF
   // An idle envelope always reports a zero level.
   a_idle_level_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running) |-> (rsp_env_level == '0))
      else $error("idle envelope reports a non-zero level");

   // The level never exceeds full scale.
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_env_level <= adsr_pkg::FULL_SCALE))
      else $error("envelope level above full scale");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIVW))
      else $error("divider finished outside the wait state");

   // An accepted transaction always starts the state update next.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_STEP))
      else $error("accepted transaction did not start the update");
`endif

endmodule
